// ===== rtl/mep_pkg.sv =====
// Shared types, constants and palette for the Mandelbrot escape-time pixel core.
`default_nettype none
package mep_pkg;

  localparam int unsigned FracBits    = 28;
  localparam int unsigned CoordW      = 36;
  localparam int unsigned PointW      = 48;
  localparam int unsigned IterW       = 16;
  localparam int unsigned IndexW      = 10;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned DefMaxCols  = 1024;
  localparam int unsigned DefMaxRows  = 1024;

  localparam logic [CoordW-1:0] XOriginRst = 36'hFE0000000;
  localparam logic [CoordW-1:0] YOriginRst = 36'hFE8000000;
  localparam logic [CoordW-1:0] StepRst    = 36'd786432;
  localparam logic [IterW-1:0]  LimitRst   = 16'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_ORIGIN = 3'd0,
    CFG_Y_ORIGIN = 3'd1,
    CFG_X_STEP   = 3'd2,
    CFG_Y_STEP   = 3'd3,
    CFG_MAX_ITER = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [IndexW-1:0] column;
    logic [IndexW-1:0] row;
  } pix_in_t;

  typedef struct packed {
    logic [IterW-1:0] iterations;
    logic             escaped;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } pix_out_t;

  typedef struct packed {
    logic signed [PointW-1:0] cre;
    logic signed [PointW-1:0] cim;
  } point_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DIV,
    ST_DONE
  } back_st_e;

  function automatic rgb_t palette(input logic [2:0] idx);
    rgb_t c;
    case (idx)
      3'd0:    c = '{r: 8'd0,   g: 8'd7,   b: 8'd100};
      3'd1:    c = '{r: 8'd32,  g: 8'd107, b: 8'd203};
      3'd2:    c = '{r: 8'd237, g: 8'd255, b: 8'd255};
      3'd3:    c = '{r: 8'd255, g: 8'd170, b: 8'd0};
      default: c = '{r: 8'd0,   g: 8'd2,   b: 8'd0};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] w);
    logic [17:0] s;
    s = 18'(9'd256 - {1'b0, w}) * 18'(a) + 18'(w) * 18'(b);
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mep_front.sv =====
// Front end: accepts pixel indexes, clamps them and forms the point c.
`default_nettype none
module mep_front #(
  parameter int unsigned MaxColumns = mep_pkg::DefMaxCols,
  parameter int unsigned MaxRows    = mep_pkg::DefMaxRows
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire mep_pkg::pix_in_t              in_data_i,
  output logic                               full_o,
  input  wire logic [mep_pkg::CoordW-1:0]    x_origin_i,
  input  wire logic [mep_pkg::CoordW-1:0]    y_origin_i,
  input  wire logic [mep_pkg::CoordW-1:0]    x_step_i,
  input  wire logic [mep_pkg::CoordW-1:0]    y_step_i,
  output logic                               wr_o,
  output mep_pkg::point_t                    wr_data_o,
  input  wire logic                          wr_full_i
);

  logic                           valid_q, valid_d;
  logic [mep_pkg::IndexW-1:0]     col_q, row_q;
  logic [mep_pkg::IndexW-1:0]     col_c, row_c;
  logic signed [46:0]             xprod, yprod;
  logic                           accept;

  assign full_o = valid_q && wr_full_i;
  assign accept = push_i && !full_o;
  assign wr_o   = valid_q && !wr_full_i;
  assign valid_d = accept || (valid_q && wr_full_i);

  assign col_c = ({7'd0, in_data_i.column} >= 17'(MaxColumns)) ?
                 mep_pkg::IndexW'(MaxColumns - 1) : in_data_i.column;
  assign row_c = ({7'd0, in_data_i.row} >= 17'(MaxRows)) ?
                 mep_pkg::IndexW'(MaxRows - 1) : in_data_i.row;

  assign xprod = $signed({1'b0, col_q}) * $signed(x_step_i);
  assign yprod = $signed({1'b0, row_q}) * $signed(y_step_i);
  assign wr_data_o.cre = $signed({{12{x_origin_i[35]}}, x_origin_i}) +
                         $signed({xprod[46], xprod});
  assign wr_data_o.cim = $signed({{12{y_origin_i[35]}}, y_origin_i}) +
                         $signed({yprod[46], yprod});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= col_c;
      row_q <= row_c;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mep_queue.sv =====
// Two-entry queue of points between the front end and the iteration engine.
`default_nettype none
module mep_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  wire mep_pkg::point_t wr_data_i,
  output logic                 full_o,
  input  wire logic            rd_i,
  output mep_pkg::point_t      rd_data_o,
  output logic                 empty_o
);

  mep_pkg::point_t mem_q [2];
  logic            wp_q, wp_d, rp_q, rp_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];
  assign wp_d      = do_wr ? !wp_q : wp_q;
  assign rp_d      = do_rd ? !rp_q : rp_q;
  assign cnt_d     = cnt_q + 2'(do_wr) - 2'(do_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mep_back.sv =====
// Iteration engine: z = z^2 + c, escape test, palette position divide and blend.
`default_nettype none
module mep_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [mep_pkg::IterW-1:0]   limit_i,
  input  wire logic                        q_empty_i,
  input  wire mep_pkg::point_t             q_data_i,
  output logic                             q_rd_o,
  output logic                             empty_o,
  input  wire logic                        pop_i,
  output mep_pkg::pix_out_t                out_data_o
);

  localparam int unsigned F = mep_pkg::FracBits;
  localparam logic signed [49:0] Two  = 50'sd1 <<< (F + 1);
  localparam logic signed [32:0] Four = 33'sd1 <<< (F + 2);

  mep_pkg::back_st_e st_q, st_d;
  logic signed [mep_pkg::PointW-1:0] cre_q, cre_d, cim_q, cim_d;
  logic signed [30:0] re_q, re_d, im_q, im_d;
  logic signed [31:0] srr_q, srr_d, sii_q, sii_d;
  logic signed [33:0] sri_q, sri_d;
  logic [mep_pkg::IterW-1:0] cnt_q, cnt_d, iter_q, iter_d;
  logic esc_q, esc_d;
  logic [16:0] rem_q, rem_d;
  logic [9:0]  pos_q, pos_d;
  logic [3:0]  dstep_q, dstep_d;
  logic        rv_q, rv_d;
  mep_pkg::pix_out_t res_q, res_d;

  logic signed [61:0] p_rr, p_ii, p_ri;
  logic signed [49:0] nre, nim;
  logic signed [32:0] mag;
  logic [17:0]        rem2;
  mep_pkg::rgb_t      c0, c1, cl;

  assign p_rr = re_q * re_q;
  assign p_ii = im_q * im_q;
  assign p_ri = re_q * im_q;
  assign mag  = {srr_q[31], srr_q} + {sii_q[31], sii_q};
  assign nre  = 50'(srr_q) - 50'(sii_q) + 50'(cre_q);
  assign nim  = 50'(sri_q) + 50'(cim_q);
  assign rem2 = {rem_q, 1'b0};
  assign c0   = mep_pkg::palette({1'b0, pos_q[9:8]});
  assign c1   = mep_pkg::palette(3'({1'b0, pos_q[9:8]} + 3'd1));
  assign cl   = mep_pkg::palette(3'd4);

  assign empty_o    = !rv_q;
  assign out_data_o = res_q;

  always_comb begin
    st_d = st_q;  cre_d = cre_q;  cim_d = cim_q;  re_d = re_q;  im_d = im_q;
    srr_d = srr_q;  sii_d = sii_q;  sri_d = sri_q;  cnt_d = cnt_q;  iter_d = iter_q;
    esc_d = esc_q;  rem_d = rem_q;  pos_d = pos_q;  dstep_d = dstep_q;
    res_d = res_q;  rv_d = rv_q && !pop_i;  q_rd_o = 1'b0;
    case (st_q)
      mep_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_rd_o = 1'b1;
          cre_d  = q_data_i.cre;
          cim_d  = q_data_i.cim;
          re_d   = '0;
          im_d   = '0;
          cnt_d  = '0;
          st_d   = mep_pkg::ST_MUL;
        end
      end
      mep_pkg::ST_MUL: begin
        srr_d = p_rr[59:28];
        sii_d = p_ii[59:28];
        sri_d = p_ri[60:27];
        st_d  = mep_pkg::ST_UPD;
      end
      mep_pkg::ST_UPD: begin
        if (cnt_q != '0 && mag > Four) begin
          esc_d  = 1'b1;
          iter_d = cnt_q - 16'd1;
          st_d   = mep_pkg::ST_DIV;
        end else if (cnt_q == limit_i) begin
          esc_d  = 1'b0;
          iter_d = cnt_q;
          st_d   = mep_pkg::ST_DONE;
        end else if (nre > Two || nre < -Two || nim > Two || nim < -Two) begin
          esc_d  = 1'b1;
          iter_d = cnt_q;
          st_d   = mep_pkg::ST_DIV;
        end else begin
          re_d  = nre[30:0];
          im_d  = nim[30:0];
          cnt_d = cnt_q + 16'd1;
          st_d  = mep_pkg::ST_MUL;
        end
        rem_d   = {1'b0, iter_d};
        dstep_d = 4'd9;
      end
      mep_pkg::ST_DIV: begin
        if (rem2 >= {2'b0, limit_i}) begin
          rem_d = 17'(rem2 - {2'b0, limit_i});
          pos_d = {pos_q[8:0], 1'b1};
        end else begin
          rem_d = rem2[16:0];
          pos_d = {pos_q[8:0], 1'b0};
        end
        dstep_d = dstep_q - 4'd1;
        if (dstep_q == 4'd0) begin
          st_d = mep_pkg::ST_DONE;
        end
      end
      mep_pkg::ST_DONE: begin
        if (!rv_q || pop_i) begin
          res_d.iterations = iter_q;
          res_d.escaped    = esc_q;
          if (esc_q) begin
            res_d.red   = mep_pkg::blend(c0.r, c1.r, pos_q[7:0]);
            res_d.green = mep_pkg::blend(c0.g, c1.g, pos_q[7:0]);
            res_d.blue  = mep_pkg::blend(c0.b, c1.b, pos_q[7:0]);
          end else begin
            res_d.red   = cl.r;
            res_d.green = cl.g;
            res_d.blue  = cl.b;
          end
          rv_d = 1'b1;
          st_d = mep_pkg::ST_IDLE;
        end
      end
      default: st_d = mep_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= mep_pkg::ST_IDLE;
      rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cre_q <= cre_d;  cim_q <= cim_d;  re_q <= re_d;  im_q <= im_d;
    srr_q <= srr_d;  sii_q <= sii_d;  sri_q <= sri_d;  cnt_q <= cnt_d;
    iter_q <= iter_d;  esc_q <= esc_d;  rem_q <= rem_d;  pos_q <= pos_d;
    dstep_q <= dstep_d;  res_q <= res_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mep_pkg::ST_UPD) |-> (cnt_q <= limit_i))
    else $error("iteration count passed the limit");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mep_pkg::ST_DIV) |-> ({1'b0, rem_q} < {2'b0, limit_i}))
    else $error("divider remainder out of range");
  a_esc_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && res_q.escaped) |-> (res_q.iterations < limit_i))
    else $error("escaped result at or above the limit");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |-> (st_q == mep_pkg::ST_IDLE && !q_empty_i))
    else $error("queue read outside idle");

endmodule
`default_nettype wire

// ===== rtl/mandelbrot_escape_time_pixel_core.sv =====
// Top level of the Mandelbrot escape-time pixel core.
// Each pixel transfer is mapped to c and iterated in a shared engine, where an iteration
// passes through a state that registers the three products and a state for update and
// escape test. A pixel that escapes, caught by the bound test or the magnitude test,
// then goes through a bit-serial divide for the palette position; one that reaches the
// limit L skips the divide. A registered front stage and a two-entry point queue keep
// accepting pixels while the engine is busy, and one result register holds the
// finished pixel until it is popped.
`default_nettype none
module mandelbrot_escape_time_pixel_core #(
  parameter int unsigned MaxColumns = mep_pkg::DefMaxCols,
  parameter int unsigned MaxRows    = mep_pkg::DefMaxRows
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire mep_pkg::pix_in_t              in_data_i,
  output logic                               empty,
  input  wire logic                          pop,
  output mep_pkg::pix_out_t                  out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mep_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mep_pkg::CoordW-1:0]    cfg_data_i
);

  logic [mep_pkg::CoordW-1:0] x_origin_q, y_origin_q, x_step_q, y_step_q;
  logic [mep_pkg::IterW-1:0]  limit_q;
  logic                       q_wr, q_full, q_rd, q_empty;
  mep_pkg::point_t            q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= mep_pkg::XOriginRst;
      y_origin_q <= mep_pkg::YOriginRst;
      x_step_q   <= mep_pkg::StepRst;
      y_step_q   <= mep_pkg::StepRst;
      limit_q    <= mep_pkg::LimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mep_pkg::CFG_X_ORIGIN: x_origin_q <= cfg_data_i;
        mep_pkg::CFG_Y_ORIGIN: y_origin_q <= cfg_data_i;
        mep_pkg::CFG_X_STEP:   x_step_q   <= cfg_data_i;
        mep_pkg::CFG_Y_STEP:   y_step_q   <= cfg_data_i;
        mep_pkg::CFG_MAX_ITER: limit_q    <= cfg_data_i[mep_pkg::IterW-1:0];
        default: ;
      endcase
    end
  end

  mep_front #(.MaxColumns(MaxColumns), .MaxRows(MaxRows)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .in_data_i, .full_o(full),
    .x_origin_i(x_origin_q), .y_origin_i(y_origin_q),
    .x_step_i(x_step_q), .y_step_i(y_step_q),
    .wr_o(q_wr), .wr_data_o(q_wdata), .wr_full_i(q_full)
  );

  mep_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i(q_wr), .wr_data_i(q_wdata), .full_o(q_full),
    .rd_i(q_rd), .rd_data_o(q_rdata), .empty_o(q_empty)
  );

  mep_back u_back (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .q_empty_i(q_empty), .q_data_i(q_rdata), .q_rd_o(q_rd),
    .empty_o(empty), .pop_i(pop), .out_data_o
  );

endmodule
`default_nettype wire

// ===== test/mandelbrot_escape_time_pixel_core_tb.sv =====
// Testbench for the Mandelbrot escape-time pixel core: predicts each pixel and checks every result.
module mandelbrot_escape_time_pixel_core_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  mep_pkg::pix_in_t in_data_i = '0;
  logic empty;
  logic pop = 1'b0;
  mep_pkg::pix_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [mep_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [mep_pkg::CoordW-1:0] cfg_data_i = '0;

  mandelbrot_escape_time_pixel_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_data_i(in_data_i),
    .empty(empty), .pop(pop), .out_data_o(out_data_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  localparam int PalR[5] = '{0, 32, 237, 255, 0};
  localparam int PalG[5] = '{7, 107, 255, 170, 2};
  localparam int PalB[5] = '{100, 203, 255, 0, 0};

  logic [mep_pkg::CoordW-1:0] x_org = mep_pkg::XOriginRst, y_org = mep_pkg::YOriginRst;
  logic [mep_pkg::CoordW-1:0] x_stp = mep_pkg::StepRst, y_stp = mep_pkg::StepRst;
  logic [mep_pkg::IterW-1:0] iter_limit = mep_pkg::LimitRst;

  mep_pkg::pix_out_t pixel_q[$];
  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;

  function automatic longint fx_mul(longint a, longint b, int sh);
    logic signed [127:0] p;
    p = 128'(a);
    p = p * 128'(b);
    p = p >>> sh;
    return longint'(p);
  endfunction

  function automatic mep_pkg::pix_out_t escape_pixel(mep_pkg::pix_in_t px);
    mep_pkg::pix_out_t r;
    longint cre, cim, re, im, nre, nim, two, four;
    int unsigned count, pos, idx, w;
    logic esc;
    two = longint'(1) << (mep_pkg::FracBits + 1);
    four = longint'(1) << (mep_pkg::FracBits + 2);
    cre = longint'($signed(x_org)) + longint'(px.column) * longint'($signed(x_stp));
    cim = longint'($signed(y_org)) + longint'(px.row) * longint'($signed(y_stp));
    re = 0;
    im = 0;
    esc = 1'b0;
    count = 0;
    while (count < iter_limit && !esc) begin
      nre = fx_mul(re, re, mep_pkg::FracBits) - fx_mul(im, im, mep_pkg::FracBits) + cre;
      nim = fx_mul(re, im, mep_pkg::FracBits - 1) + cim;
      re = nre;
      im = nim;
      if (re > two || re < -two || im > two || im < -two) esc = 1'b1;
      else if (fx_mul(re, re, mep_pkg::FracBits) + fx_mul(im, im, mep_pkg::FracBits) > four)
        esc = 1'b1;
      if (!esc) count++;
    end
    r.iterations = count[15:0];
    r.escaped = esc;
    if (count >= iter_limit) begin
      r.red = 8'(PalR[4]);
      r.green = 8'(PalG[4]);
      r.blue = 8'(PalB[4]);
    end else begin
      pos = (count * 1024) / iter_limit;
      idx = (pos >> 8) & 3;
      w = pos & 255;
      r.red = 8'(((256 - w) * PalR[idx] + w * PalR[idx + 1]) >> 8);
      r.green = 8'(((256 - w) * PalG[idx] + w * PalG[idx + 1]) >> 8);
      r.blue = 8'(((256 - w) * PalB[idx] + w * PalB[idx + 1]) >> 8);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    mep_pkg::pix_out_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: %h", out_data_o);
        end else begin
          e = pixel_q.pop_front();
          if (e.iterations !== out_data_o.iterations || e.escaped !== out_data_o.escaped ||
              e.red !== out_data_o.red || e.green !== out_data_o.green ||
              e.blue !== out_data_o.blue) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp it=%0d esc=%0b rgb=%h%h%h got it=%0d esc=%0b rgb=%h%h%h",
                       e.iterations, e.escaped, e.red, e.green, e.blue,
                       out_data_o.iterations, out_data_o.escaped, out_data_o.red,
                       out_data_o.green, out_data_o.blue);
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_pixel(logic [9:0] col, logic [9:0] row);
    mep_pkg::pix_in_t px;
    px.column = col;
    px.row = row;
    push <= 1'b1;
    in_data_i <= px;
    do @(posedge clk_i); while (full);
    pixel_q.push_back(escape_pixel(px));
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic stop_push();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [mep_pkg::CfgIdxW-1:0] idx,
                           logic [mep_pkg::CoordW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mep_pkg::CFG_X_ORIGIN: x_org = val;
      mep_pkg::CFG_Y_ORIGIN: y_org = val;
      mep_pkg::CFG_X_STEP: x_stp = val;
      mep_pkg::CFG_Y_STEP: y_stp = val;
      mep_pkg::CFG_MAX_ITER: iter_limit = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_view(logic [35:0] xo, logic [35:0] yo, logic [35:0] xs, logic [35:0] ys,
                          logic [15:0] lim);
    write_reg(mep_pkg::CFG_X_ORIGIN, xo);
    write_reg(mep_pkg::CFG_Y_ORIGIN, yo);
    write_reg(mep_pkg::CFG_X_STEP, xs);
    write_reg(mep_pkg::CFG_Y_STEP, ys);
    write_reg(mep_pkg::CFG_MAX_ITER, {20'h0, lim});
  endtask

  task automatic test_reset_view();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd683, 10'd512);
    send_pixel(10'd600, 10'd700);
    send_pixel(10'd400, 10'd300);
    stop_push();
    drain();
  endtask

  task automatic test_limits();
    set_view('0, '0, 36'd1000, 36'd1000, 16'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    stop_push();
    drain();
    write_reg(mep_pkg::CFG_MAX_ITER, 36'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    stop_push();
    drain();
    set_view(36'hFE0000000, 36'hFE8000000, 36'd786432, 36'd786432, 16'd7);
    send_pixel(10'd100, 10'd512);
    send_pixel(10'd683, 10'd512);
    send_pixel(10'd0, 10'd1023);
    stop_push();
    drain();
    set_view('0, '0, 36'd1, 36'd1, 16'hFFFF);
    send_pixel(10'd0, 10'd0);
    stop_push();
    drain();
  endtask

  task automatic test_extreme_regs();
    set_view(36'h7FFFFFFFF, 36'h800000000, 36'h7FFFFFFFF, 36'h800000000, 16'd5);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    stop_push();
    drain();
    set_view(36'h800000000, 36'h7FFFFFFFF, 36'h800000000, 36'h7FFFFFFFF, 16'd3);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    stop_push();
    drain();
    // writes to unused indexes must not disturb any register
    write_reg(3'(mep_pkg::CFG_MAX_ITER) + 3'd1, 36'hFFFFFFFFF);
    write_reg(3'(mep_pkg::CFG_MAX_ITER) + 3'd2, 36'h0);
    write_reg(3'(mep_pkg::CFG_MAX_ITER) + 3'd3, 36'h123456789);
    send_pixel(10'd512, 10'd512);
    stop_push();
    drain();
  endtask

  task automatic test_random(int s_idle, int r_idle, int n_items);
    int sent;
    longint xo, yo;
    logic [35:0] xs, ys;
    int n;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        set_view(36'({$urandom, $urandom}), 36'({$urandom, $urandom}),
                 36'({$urandom, $urandom}), 36'({$urandom, $urandom}), 16'($urandom));
        n = 10;
      end else begin
        xo = longint'($urandom_range(0, 939524096)) - 671088640;
        yo = longint'($urandom_range(0, 805306368)) - 402653184;
        xs = 36'($urandom_range(1, 1 << 20));
        ys = 36'($urandom_range(1, 1 << 20));
        if ($urandom_range(1)) xs = -xs;
        if ($urandom_range(1)) ys = -ys;
        set_view(36'(xo), 36'(yo), xs, ys,
                 ($urandom_range(7) == 0) ? 16'd256 : 16'($urandom_range(1, 64)));
        n = 40;
      end
      repeat (n) send_pixel(10'($urandom), 10'($urandom));
      sent += n;
      stop_push();
      drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_view();
    test_limits();
    test_extreme_regs();
    test_random(31, 66, 620);
    test_random(66, 31, 620);
    test_random(0, 0, 620);
    drain();
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
